### rtl/irwpd_pkg.sv
// shared types, constants and codes for the ir window peak wall detector
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps

package irwpd_pkg;

    // depth of each per-channel delay line
    localparam int WINDOW     = 8;
    localparam int WIN_IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WIN_CNT_W  = $clog2(WINDOW + 1);

    localparam int SAMPLE_W   = 12;
    localparam int MV_W       = 14;
    localparam int BARS_W     = 3;
    localparam int SCALE_W    = 14;
    localparam int PROD_W     = SAMPLE_W + SCALE_W;

    // item kinds carried in tuser
    localparam logic [1:0] MODE_FRONT = 2'd0;
    localparam logic [1:0] MODE_SIDE  = 2'd1;
    localparam logic [1:0] MODE_EVAL  = 2'd2;

    // configuration register indexes and reset values
    localparam logic REG_WALL_THRESHOLD = 1'b0;
    localparam logic REG_START_LEVEL    = 1'b1;
    localparam logic [SAMPLE_W-1:0] WALL_THRESHOLD_RST = 12'd1000;
    localparam logic [SAMPLE_W-1:0] START_LEVEL_RST    = 12'd2700;

    // battery divider: millivolts = raw * 9900 / 4096
    localparam logic [SCALE_W-1:0] BAT_SCALE   = 14'd9900;
    localparam logic [PROD_W-1:0]  BAT_LVL_4V  = PROD_W'(4 * 1000 * 4096);
    localparam logic [PROD_W-1:0]  BAT_LVL_5V  = PROD_W'(5 * 1000 * 4096);
    localparam logic [PROD_W-1:0]  BAT_LVL_6V  = PROD_W'(6 * 1000 * 4096);
    localparam logic [PROD_W-1:0]  BAT_LVL_7V  = PROD_W'(7 * 1000 * 4096);

    // four channels: 0 front left, 1 front right, 2 side left, 3 side right
    typedef logic [3:0][SAMPLE_W-1:0] t_quad;

    typedef struct packed {
        logic                 push_front;
        logic                 push_side;
        logic [SAMPLE_W-1:0]  left;
        logic [SAMPLE_W-1:0]  right;
        logic [WIN_IDX_W-1:0] rd_idx;
    } t_win_ctrl;

endpackage

### rtl/irwpd_window_bank.sv
// four per-channel delay lines with one indexed read tap per channel
// depends on irwpd_pkg
`timescale 1ns / 1ps

module irwpd_window_bank (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  irwpd_pkg::t_win_ctrl i_ctrl,
    output irwpd_pkg::t_quad     o_taps
);

    logic [irwpd_pkg::SAMPLE_W-1:0] r_fl [irwpd_pkg::WINDOW];
    logic [irwpd_pkg::SAMPLE_W-1:0] r_fr [irwpd_pkg::WINDOW];
    logic [irwpd_pkg::SAMPLE_W-1:0] r_sl [irwpd_pkg::WINDOW];
    logic [irwpd_pkg::SAMPLE_W-1:0] r_sr [irwpd_pkg::WINDOW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < irwpd_pkg::WINDOW; i++) begin
                r_fl[i] <= '0;
                r_fr[i] <= '0;
                r_sl[i] <= '0;
                r_sr[i] <= '0;
            end
        end else begin
            if (i_ctrl.push_front) begin
                for (int i = irwpd_pkg::WINDOW - 1; i > 0; i--) begin
                    r_fl[i] <= r_fl[i-1];
                    r_fr[i] <= r_fr[i-1];
                end
                r_fl[0] <= i_ctrl.left;
                r_fr[0] <= i_ctrl.right;
            end
            if (i_ctrl.push_side) begin
                for (int i = irwpd_pkg::WINDOW - 1; i > 0; i--) begin
                    r_sl[i] <= r_sl[i-1];
                    r_sr[i] <= r_sr[i-1];
                end
                r_sl[0] <= i_ctrl.left;
                r_sr[0] <= i_ctrl.right;
            end
        end
    end

    assign o_taps[0] = r_fl[i_ctrl.rd_idx];
    assign o_taps[1] = r_fr[i_ctrl.rd_idx];
    assign o_taps[2] = r_sl[i_ctrl.rd_idx];
    assign o_taps[3] = r_sr[i_ctrl.rd_idx];

endmodule

### rtl/irwpd_cmp_unit.sv
// shared four-lane unsigned greater-than unit used for peak scan and level checks
// depends on irwpd_pkg
`timescale 1ns / 1ps

module irwpd_cmp_unit (
    input  irwpd_pkg::t_quad i_a,
    input  irwpd_pkg::t_quad i_b,
    output logic [3:0]       o_gt
);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_gt[i] = (i_a[i] > i_b[i]);
        end
    end

endmodule

### rtl/irwpd_battery_conv.sv
// battery raw sample to millivolts and bar count, one registered stage
// depends on irwpd_pkg
`timescale 1ns / 1ps

module irwpd_battery_conv (
    input  logic                             i_clk,
    input  logic [irwpd_pkg::SAMPLE_W-1:0]   i_raw,
    output logic [irwpd_pkg::MV_W-1:0]       o_millivolts,
    output logic [irwpd_pkg::BARS_W-1:0]     o_bars
);

    logic [irwpd_pkg::PROD_W-1:0] scaled;
    logic [irwpd_pkg::BARS_W-1:0] bars;
    logic [irwpd_pkg::MV_W-1:0]   r_millivolts;
    logic [irwpd_pkg::BARS_W-1:0] r_bars;

    assign scaled = irwpd_pkg::PROD_W'(i_raw) * irwpd_pkg::PROD_W'(irwpd_pkg::BAT_SCALE);

    always_comb begin
        bars = irwpd_pkg::BARS_W'(scaled > irwpd_pkg::BAT_LVL_4V)
             + irwpd_pkg::BARS_W'(scaled > irwpd_pkg::BAT_LVL_5V)
             + irwpd_pkg::BARS_W'(scaled > irwpd_pkg::BAT_LVL_6V)
             + irwpd_pkg::BARS_W'(scaled > irwpd_pkg::BAT_LVL_7V);
    end

    always_ff @(posedge i_clk) begin
        r_millivolts <= scaled[irwpd_pkg::PROD_W-1:irwpd_pkg::PROD_W-irwpd_pkg::MV_W];
        r_bars       <= bars;
    end

    assign o_millivolts = r_millivolts;
    assign o_bars       = r_bars;

endmodule

### rtl/ir_window_peak_wall_detector_unit.sv
// Conditions four ir reflectance channels and a battery channel. A front or side
// sample passes through the start-level check and done states before it loads the
// result register; an evaluate tick first passes through the scan state, where the
// one four-lane compare unit steps through the delay lines one tap per cycle, then
// checks the wall threshold and the start level before the done state.
// A new transaction is accepted only once the previous one has reached the output
// register, which may still be waiting for tready; a finished result waits in the
// done state while the output register is busy.
// Registers at paddr 0 (wall_threshold) and 4 (start_level), 12 bits each.
// top level: sequencer, level and flag registers, config port, output register
// depends on irwpd_pkg, irwpd_window_bank, irwpd_cmp_unit, irwpd_battery_conv
`timescale 1ns / 1ps

module ir_window_peak_wall_detector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // sample_left, sample_right, battery_sample, pad
    input  logic [1:0]  i_s_axis_tuser,  // mode
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // front_left_level, front_right_level, side_left_level, side_right_level,
    // wall_flags, battery_millivolts, battery_bars, start_ready, pad
    output logic [71:0] o_m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_THRESH = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam int SW = irwpd_pkg::SAMPLE_W;

    logic [2:0]                      r_state, n_state;
    logic [irwpd_pkg::WIN_CNT_W-1:0] r_cnt, n_cnt;
    irwpd_pkg::t_quad                r_lvl, n_lvl;
    irwpd_pkg::t_quad                r_peak, n_peak;
    logic [3:0]                      r_flags, n_flags;
    logic                            r_start, n_start;
    logic [SW-1:0]                   r_bat, n_bat;
    logic [SW-1:0]                   r_wall_thr;
    logic [SW-1:0]                   r_start_lvl;
    logic                            r_m_tvalid, n_m_tvalid;
    logic [71:0]                     r_m_tdata, n_m_tdata;

    logic                            s_fire;
    logic                            cfg_wr;
    logic [1:0]                      mode;
    logic [SW-1:0]                   in_left, in_right, in_bat;
    irwpd_pkg::t_win_ctrl            win_ctrl;
    irwpd_pkg::t_quad                taps;
    irwpd_pkg::t_quad                cmp_a, cmp_b;
    logic [3:0]                      cmp_gt;
    logic [irwpd_pkg::MV_W-1:0]      bat_mv;
    logic [irwpd_pkg::BARS_W-1:0]    bat_bars;

    assign mode     = i_s_axis_tuser;
    assign in_left  = i_s_axis_tdata[SW-1:0];
    assign in_right = i_s_axis_tdata[2*SW-1:SW];
    assign in_bat   = i_s_axis_tdata[3*SW-1:2*SW];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_thr  <= irwpd_pkg::WALL_THRESHOLD_RST;
            r_start_lvl <= irwpd_pkg::START_LEVEL_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                irwpd_pkg::REG_WALL_THRESHOLD: r_wall_thr  <= pwdata[SW-1:0];
                irwpd_pkg::REG_START_LEVEL:    r_start_lvl <= pwdata[SW-1:0];
                default:                       r_wall_thr  <= r_wall_thr;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            irwpd_pkg::REG_WALL_THRESHOLD: prdata = 32'(r_wall_thr);
            irwpd_pkg::REG_START_LEVEL:    prdata = 32'(r_start_lvl);
            default:                       prdata = '0;
        endcase
    end

    // delay lines
    always_comb begin
        win_ctrl.push_front = s_fire && (mode == irwpd_pkg::MODE_FRONT);
        win_ctrl.push_side  = s_fire && (mode == irwpd_pkg::MODE_SIDE);
        win_ctrl.left       = in_left;
        win_ctrl.right      = in_right;
        win_ctrl.rd_idx     = r_cnt[irwpd_pkg::WIN_IDX_W-1:0];
    end

    irwpd_window_bank u_window_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (win_ctrl),
        .o_taps  (taps)
    );

    // shared compare unit operand select
    always_comb begin
        cmp_a = r_lvl;
        cmp_b = '0;
        unique case (r_state)
            S_SCAN: begin
                cmp_a = taps;
                cmp_b = r_peak;
            end
            S_THRESH: begin
                cmp_b = {4{r_wall_thr}};
            end
            S_CHECK: begin
                cmp_b = {4{r_start_lvl}};
            end
            default: begin
                cmp_b = '0;
            end
        endcase
    end

    irwpd_cmp_unit u_cmp_unit (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (cmp_gt)
    );

    irwpd_battery_conv u_battery_conv (
        .i_clk        (i_clk),
        .i_raw        (r_bat),
        .o_millivolts (bat_mv),
        .o_bars       (bat_bars)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_lvl      = r_lvl;
        n_peak     = r_peak;
        n_flags    = r_flags;
        n_start    = r_start;
        n_bat      = r_bat;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;

        if (r_m_tvalid && i_m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = S_CHECK;
                    unique case (mode)
                        irwpd_pkg::MODE_FRONT: begin
                            n_lvl[0] = in_left;
                            n_lvl[1] = in_right;
                            n_bat    = in_bat;
                        end
                        irwpd_pkg::MODE_SIDE: begin
                            n_lvl[2] = in_left;
                            n_lvl[3] = in_right;
                        end
                        irwpd_pkg::MODE_EVAL: begin
                            n_peak  = '0;
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_CHECK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                for (int i = 0; i < 4; i++) begin
                    if (cmp_gt[i]) begin
                        n_peak[i] = taps[i];
                    end
                end
                if (r_cnt == irwpd_pkg::WIN_CNT_W'(irwpd_pkg::WINDOW - 1)) begin
                    n_lvl   = n_peak;
                    n_state = S_THRESH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_THRESH: begin
                n_flags = cmp_gt;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_start = cmp_gt[0] && cmp_gt[1];
                n_state = S_DONE;
            end
            S_DONE: begin
                // load the result once the output register is free
                if (!r_m_tvalid || i_m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {2'b00, r_start, bat_bars, bat_mv, r_flags,
                                  r_lvl[3], r_lvl[2], r_lvl[1], r_lvl[0]};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_lvl      <= '0;
            r_peak     <= '0;
            r_flags    <= '0;
            r_start    <= 1'b0;
            r_bat      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_lvl      <= n_lvl;
            r_peak     <= n_peak;
            r_flags    <= n_flags;
            r_start    <= n_start;
            r_bat      <= n_bat;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_tdata <= n_m_tdata;
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

endmodule

### sim/tb.sv
// self-checking testbench for ir_window_peak_wall_detector_unit
// depends on rtl/irwpd_pkg.sv and the rtl under it; stream driver, monitor, apb writes
`timescale 1ns / 1ps

module tb;

    localparam int SW  = irwpd_pkg::SAMPLE_W;
    localparam int WIN = irwpd_pkg::WINDOW;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]    mode;
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic [SW-1:0] bat;
    } t_sample;

    // packed so that it maps straight onto o_m_axis_tdata[69:0]
    typedef struct packed {
        logic                           start_ready;
        logic [irwpd_pkg::BARS_W-1:0]   bars;
        logic [irwpd_pkg::MV_W-1:0]     millivolts;
        logic [3:0]                     flags;
        logic [SW-1:0]                  side_right;
        logic [SW-1:0]                  side_left;
        logic [SW-1:0]                  front_right;
        logic [SW-1:0]                  front_left;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [71:0] o_m_axis_tdata;
    logic [31:0] prdata;
    logic        pready;

    ir_window_peak_wall_detector_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // predictor state
    logic [SW-1:0] win_taps [4][WIN];
    logic [SW-1:0] levels [4];
    logic [3:0]    wall_bits = '0;
    logic [SW-1:0] bat_raw = '0;
    logic [SW-1:0] wall_cfg = irwpd_pkg::WALL_THRESHOLD_RST;
    logic [SW-1:0] start_cfg = irwpd_pkg::START_LEVEL_RST;

    t_sample sample_queue[$];
    t_report pending_reports[$];
    t_sample in_flight;
    int      tx_idle_pct = 13;
    int      rx_idle_pct = 72;
    logic    rx_hold = 1'b0;
    bit      stall_req = 1'b0;
    int      accepted = 0;
    int      reports_seen = 0;
    int      mismatches = 0;
    int      eval_count = 0;

    initial begin
        for (int c = 0; c < 4; c++) begin
            levels[c] = '0;
            for (int i = 0; i < WIN; i++) win_taps[c][i] = '0;
        end
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic void shift_pair(int ch, logic [SW-1:0] a, logic [SW-1:0] b);
        for (int i = WIN - 1; i > 0; i--) begin
            win_taps[ch][i]     = win_taps[ch][i-1];
            win_taps[ch + 1][i] = win_taps[ch + 1][i-1];
        end
        win_taps[ch][0]     = a;
        win_taps[ch + 1][0] = b;
        levels[ch]          = a;
        levels[ch + 1]      = b;
    endfunction

    function automatic t_report sensor_report(t_sample it);
        t_report       r;
        int unsigned   scaled;
        int unsigned   nbars;
        logic [SW-1:0] pk;
        case (it.mode)
            irwpd_pkg::MODE_FRONT: begin
                shift_pair(0, it.left, it.right);
                bat_raw = it.bat;
            end
            irwpd_pkg::MODE_SIDE: shift_pair(2, it.left, it.right);
            irwpd_pkg::MODE_EVAL: begin
                for (int c = 0; c < 4; c++) begin
                    pk = '0;
                    for (int i = 0; i < WIN; i++)
                        if (win_taps[c][i] > pk) pk = win_taps[c][i];
                    levels[c]    = pk;
                    wall_bits[c] = pk > wall_cfg;
                end
            end
            default: ;
        endcase
        scaled = bat_raw * 9900;
        nbars = 0;
        for (int v = 4; v <= 7; v++)
            if (scaled > v * 1000 * 4096) nbars++;
        r.front_left  = levels[0];
        r.front_right = levels[1];
        r.side_left   = levels[2];
        r.side_right  = levels[3];
        r.flags       = wall_bits;
        r.millivolts  = irwpd_pkg::MV_W'(scaled / 4096);
        r.bars        = irwpd_pkg::BARS_W'(nbars);
        r.start_ready = (levels[0] > start_cfg) && (levels[1] > start_cfg);
        return r;
    endfunction

    // stream driver
    always @(posedge i_clk) begin
        if (s_valid && o_s_axis_tready) begin
            pending_reports.push_back(sensor_report(in_flight));
            accepted++;
            if (in_flight.mode == irwpd_pkg::MODE_EVAL) eval_count++;
        end
        if (!s_valid || o_s_axis_tready) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                in_flight = sample_queue.pop_front();
                s_valid <= 1'b1;
                s_tdata <= {4'b0, in_flight.bat, in_flight.right, in_flight.left};
                s_tuser <= in_flight.mode;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        m_ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
        if (o_m_axis_tvalid === 1'b1 && m_ready) begin
            got = t_report'(o_m_axis_tdata[69:0]);
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", o_m_axis_tdata);
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d mismatch (levels fl fr sl sr, flags, mv, bars, start)",
                                 reports_seen);
                        $display("  exp %0d %0d %0d %0d, %h, %0d, %0d, %b",
                                 want.front_left, want.front_right, want.side_left,
                                 want.side_right, want.flags, want.millivolts,
                                 want.bars, want.start_ready);
                        $display("  got %0d %0d %0d %0d, %h, %0d, %0d, %b",
                                 got.front_left, got.front_right, got.side_left,
                                 got.side_right, got.flags, got.millivolts,
                                 got.bars, got.start_ready);
                    end
                end
            end
        end
    end

    // long output stall so the block backs up onto its input
    initial begin
        wait (stall_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic write_reg(input logic idx, input logic [SW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {20'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == irwpd_pkg::REG_WALL_THRESHOLD) wall_cfg = val;
        else start_cfg = val;
    endtask

    task automatic add_sample(logic [1:0] m, int l, int r, int b);
        t_sample it;
        it.mode  = m;
        it.left  = SW'(l);
        it.right = SW'(r);
        it.bat   = SW'(b);
        sample_queue.push_back(it);
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_valid || pending_reports.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic int near(int base);
        int v;
        v = base + $urandom_range(6) - 3;
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    function automatic int pick_level();
        case ($urandom_range(9))
            0:       return near(int'(wall_cfg));
            1:       return near(int'(start_cfg));
            2:       return 0;
            3:       return 4095;
            default: return $urandom_range(4095);
        endcase
    endfunction

    function automatic int pick_battery();
        int edges[4] = '{1655, 2069, 2483, 2897};
        if ($urandom_range(3) == 0) return near(edges[$urandom_range(3)]);
        return $urandom_range(4095);
    endfunction

    // groups of samples closed by an evaluate, with some noise and open groups
    task automatic add_random(int n);
        int cnt;
        int len;
        cnt = 0;
        while (cnt < n) begin
            len = $urandom_range(1, 11);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(19) == 0)
                    add_sample(MODE_UNUSED, $urandom_range(4095), $urandom_range(4095),
                               $urandom_range(4095));
                else
                    add_sample($urandom_range(1) ? irwpd_pkg::MODE_FRONT
                                                 : irwpd_pkg::MODE_SIDE,
                               pick_level(), pick_level(), pick_battery());
                cnt++;
            end
            if ($urandom_range(7) != 0) begin
                add_sample(irwpd_pkg::MODE_EVAL, $urandom_range(4095), $urandom_range(4095),
                           $urandom_range(4095));
                cnt++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at reset thresholds
        add_sample(irwpd_pkg::MODE_EVAL, 0, 0, 0);
        add_sample(irwpd_pkg::MODE_FRONT, 0, 0, 0);
        add_sample(irwpd_pkg::MODE_FRONT, 4095, 4095, 4095);
        add_sample(irwpd_pkg::MODE_SIDE, 4095, 0, 1234);
        add_sample(irwpd_pkg::MODE_SIDE, 0, 4095, 0);
        add_sample(irwpd_pkg::MODE_EVAL, 0, 0, 0);
        add_sample(MODE_UNUSED, 4095, 4095, 4095);
        add_sample(irwpd_pkg::MODE_FRONT, 2700, 2701, 1654);
        add_sample(irwpd_pkg::MODE_FRONT, 2701, 2701, 1655);
        add_sample(irwpd_pkg::MODE_SIDE, 1000, 1001, 4095);
        add_sample(irwpd_pkg::MODE_EVAL, 4095, 4095, 4095);
        add_sample(irwpd_pkg::MODE_FRONT, 1000, 1001, 2068);
        add_sample(irwpd_pkg::MODE_FRONT, 0, 0, 2069);
        add_sample(irwpd_pkg::MODE_FRONT, 0, 0, 2482);
        add_sample(irwpd_pkg::MODE_FRONT, 0, 0, 2483);
        add_sample(irwpd_pkg::MODE_FRONT, 0, 0, 2896);
        add_sample(irwpd_pkg::MODE_FRONT, 0, 0, 2897);
        add_sample(MODE_UNUSED, 0, 0, 0);
        // oldest peaks fall out of the window
        for (int k = 0; k < WIN; k++) add_sample(irwpd_pkg::MODE_SIDE, 999, 1000, 0);
        add_sample(irwpd_pkg::MODE_EVAL, 0, 0, 0);
        add_random(400);
        wait_drained();

        // lowest thresholds, idling swapped
        write_reg(irwpd_pkg::REG_WALL_THRESHOLD, 12'd0);
        write_reg(irwpd_pkg::REG_START_LEVEL, 12'd0);
        tx_idle_pct = 72;
        rx_idle_pct = 13;
        add_sample(irwpd_pkg::MODE_FRONT, 1, 0, 7);
        add_sample(irwpd_pkg::MODE_EVAL, 0, 0, 0);
        add_random(300);
        wait_drained();

        // highest thresholds, no idling, long output stall
        write_reg(irwpd_pkg::REG_WALL_THRESHOLD, 12'd4095);
        write_reg(irwpd_pkg::REG_START_LEVEL, 12'd4095);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_req = 1'b1;
        add_random(250);
        wait_drained();

        write_reg(irwpd_pkg::REG_WALL_THRESHOLD, SW'($urandom_range(4095)));
        write_reg(irwpd_pkg::REG_START_LEVEL, SW'($urandom_range(4095)));
        add_random(250);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (pending_reports.size() != 0) mismatches++;
        $display("summary: %0d transactions in (%0d evaluates), %0d results checked",
                 accepted, eval_count, reports_seen);
        $display("summary: thresholds at reset, both extremes and random; one long output stall");
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/irwpd_pkg.sv
rtl/irwpd_window_bank.sv
rtl/irwpd_cmp_unit.sv
rtl/irwpd_battery_conv.sv
rtl/ir_window_peak_wall_detector_unit.sv
sim/tb.sv
